### sv/lzss_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// LZSS decompressor package
// Shared sizes, controller state encoding and the command and status groups
// that pass between the controller and the datapath.
// ============================================================================
package lzss_pkg;

    // Window index width; the history window holds 2**POSITION_BITS bytes.
    localparam int POSITION_BITS    = 12;
    // Width of the encoded copy length.
    localparam int LENGTH_BITS      = 4;
    // A match copies length_code + MIN_MATCH_OFFSET + 1 bytes.
    localparam int MIN_MATCH_OFFSET = 1;
    localparam int BYTE_BITS        = 8;

    localparam int WIN_DEPTH = 1 << POSITION_BITS;
    localparam int MAX_RUN   = (1 << LENGTH_BITS) - 1 + MIN_MATCH_OFFSET + 1;
    // Holds the number of bytes still to issue after the current one.
    localparam int STEP_BITS = $clog2(MAX_RUN);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_END  = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_end;
        logic can_issue;
        logic last_step;
        logic pipe_empty;
    } dp_stat_t;

endpackage

### sv/lzss_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data. The read data
// register only updates when a read is enabled.
// ============================================================================
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lzss_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// LZSS decompressor controller
// Accepts tokens, steps the datapath once per output byte and sequences the
// end-of-stream reset of the history.
// ============================================================================
module lzss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lzss_pkg::dp_stat_t stat,
    output lzss_pkg::dp_cmd_t  cmd
);

    lzss_pkg::ctrl_state_t state_reg;
    lzss_pkg::ctrl_state_t state_next;
    logic                  in_ready;
    logic                  issue;

    always_comb
    begin
        in_ready   = 1'b0;
        issue      = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            lzss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            lzss_pkg::ST_RUN:
            begin
                issue = stat.can_issue;
                // The next token may enter as the last byte of this one issues.
                in_ready = stat.can_issue && stat.last_step;
                if (issue && stat.last_step)
                begin
                    state_next = lzss_pkg::ST_IDLE;
                end
            end
            lzss_pkg::ST_END:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.clear  = 1'b1;
                    state_next = lzss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzss_pkg::ST_IDLE;
            end
        endcase

        cmd.issue = issue;
        cmd.load  = in_valid && in_ready;
        if (cmd.load)
        begin
            state_next = stat.in_is_end ? lzss_pkg::ST_END : lzss_pkg::ST_RUN;
        end
    end

    assign in_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/lzss_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// LZSS decompressor datapath
// Token registers, history window, a read stage with write forwarding and the
// output register.
// ============================================================================
module lzss_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lzss_pkg::dp_cmd_t                   cmd,
    output lzss_pkg::dp_stat_t                  stat,
    input  logic                                is_literal,
    input  logic [lzss_pkg::BYTE_BITS-1:0]      literal_byte,
    input  logic [lzss_pkg::POSITION_BITS-1:0]  match_position,
    input  logic [lzss_pkg::LENGTH_BITS-1:0]    length_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lzss_pkg::BYTE_BITS-1:0]      out_byte,
    output logic                                last_of_run
);

    // Current token.
    logic                               lit_reg;
    logic [lzss_pkg::BYTE_BITS-1:0]     byte_reg;
    logic [lzss_pkg::POSITION_BITS-1:0] src_reg;
    logic [lzss_pkg::STEP_BITS-1:0]     rem_reg;

    // Write side of the history: pointer and number of bytes written since
    // the last clear, saturating at the window size.
    logic [lzss_pkg::POSITION_BITS-1:0] wp_reg;
    logic [lzss_pkg::POSITION_BITS:0]   count_reg;
    logic                               full;

    // Read stage, one byte deep.
    logic                               p_valid_reg;
    logic                               p_lit_reg;
    logic                               p_last_reg;
    logic [lzss_pkg::BYTE_BITS-1:0]     p_byte_reg;
    logic                               p_hit_reg;
    logic [lzss_pkg::BYTE_BITS-1:0]     p_fwd_reg;
    logic                               p_known_reg;

    // Output register.
    logic                               out_valid_reg;
    logic [lzss_pkg::BYTE_BITS-1:0]     out_byte_reg;
    logic                               out_last_reg;

    logic                               out_ready;
    logic                               adv;
    logic                               hit;
    logic                               known;
    logic [lzss_pkg::BYTE_BITS-1:0]     ram_q;
    logic [lzss_pkg::BYTE_BITS-1:0]     sel_byte;

    assign full      = count_reg[lzss_pkg::POSITION_BITS];
    assign out_ready = !out_valid_reg || !out_stall;
    assign adv       = p_valid_reg && out_ready;

    // A read that hits the address being written this cycle takes the new byte.
    assign hit   = adv && (wp_reg == src_reg);
    // Entries written since the last clear are 1 .. count, or all once full.
    assign known = hit || full ||
                   ((src_reg != '0) && ({1'b0, src_reg} <= count_reg));

    always_comb
    begin
        if (p_lit_reg)
        begin
            sel_byte = p_byte_reg;
        end
        else if (p_hit_reg)
        begin
            sel_byte = p_fwd_reg;
        end
        else if (p_known_reg)
        begin
            sel_byte = ram_q;
        end
        else
        begin
            sel_byte = '0;
        end
    end

    lzss_ram #(
        .WIDTH (lzss_pkg::BYTE_BITS),
        .DEPTH (lzss_pkg::WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (adv),
        .waddr (wp_reg),
        .wdata (sel_byte),
        .re    (cmd.issue && !lit_reg),
        .raddr (src_reg),
        .rdata (ram_q)
    );

    assign stat.in_is_end  = !is_literal && (match_position == '0);
    assign stat.can_issue  = !p_valid_reg || out_ready;
    assign stat.last_step  = (rem_reg == '0);
    assign stat.pipe_empty = !p_valid_reg;

    // Token registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lit_reg  <= is_literal;
            byte_reg <= literal_byte;
            src_reg  <= match_position;
            rem_reg  <= is_literal ? '0 :
                        lzss_pkg::STEP_BITS'(length_code) +
                        lzss_pkg::STEP_BITS'(lzss_pkg::MIN_MATCH_OFFSET);
        end
        else if (cmd.issue)
        begin
            src_reg <= src_reg + lzss_pkg::POSITION_BITS'(1);
            rem_reg <= rem_reg - lzss_pkg::STEP_BITS'(1);
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            p_lit_reg   <= lit_reg;
            p_byte_reg  <= byte_reg;
            p_last_reg  <= (rem_reg == '0);
            p_hit_reg   <= hit;
            p_fwd_reg   <= sel_byte;
            p_known_reg <= known;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= p_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= lzss_pkg::POSITION_BITS'(1);
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                wp_reg    <= lzss_pkg::POSITION_BITS'(1);
                count_reg <= '0;
            end
            else if (adv)
            begin
                wp_reg <= wp_reg + lzss_pkg::POSITION_BITS'(1);
                if (!full)
                begin
                    count_reg <= count_reg + (lzss_pkg::POSITION_BITS + 1)'(1);
                end
            end

            if (cmd.issue)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                p_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

    // A byte is only issued when the read stage can hand its byte on.
    a_issue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (!p_valid_reg || out_ready))
        else $error("byte issued while the read stage is blocked");

    // The history is only cleared with no byte in flight.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (!p_valid_reg && !cmd.issue))
        else $error("history cleared with a byte in flight");

    // Until the window fills, the pointer runs one ahead of the fill count.
    a_wp_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (wp_reg == count_reg[lzss_pkg::POSITION_BITS-1:0] +
                   lzss_pkg::POSITION_BITS'(1)))
        else $error("write pointer and fill count disagree");

    // The fill count saturates exactly at the window size.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (count_reg[lzss_pkg::POSITION_BITS-1:0] == '0))
        else $error("fill count beyond window size");

    // A byte leaving the read stage always lands in the output register.
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("byte lost between read stage and output");

endmodule

### sv/lzss_token_decompressor.sv
`timescale 1ns / 1ps
// ============================================================================
// LZSS token decompressor
// Expands unpacked LZSS tokens into bytes through a 4096-byte history window.
// ============================================================================
// Usage:
// The input channel (in_valid / in_stall) carries one token per transaction:
// a literal (is_literal = 1) yields one byte, a match copies length_code + 2
// bytes from match_position upward, and a match with position 0 ends the
// stream, yields nothing and resets the history. The output channel
// (out_valid / out_stall) carries one byte per transaction; last_of_run marks
// the final byte of each token.
// Throughput is one output byte per cycle while the output is not stalled,
// limited by the single read and single write port of the window RAM, since
// the next token is taken as the last byte of the current one is issued. A
// token arriving at an idle block is loaded into the token registers before
// its first byte is issued; each byte then passes through the read stage and
// into the output register.
// An end token holds off input until in-flight bytes are written, then clears
// the history without a memory sweep, since a fill count marks which entries
// have been written.
// Reset empties the pipeline and output, and the history reads as all zeros
// with the write pointer at 1. While out_stall is high the output byte holds
// and, once the one-byte read stage is full, no further bytes are issued.
// ============================================================================
module lzss_token_decompressor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                is_literal,
    input  logic [lzss_pkg::BYTE_BITS-1:0]      literal_byte,
    input  logic [lzss_pkg::POSITION_BITS-1:0]  match_position,
    input  logic [lzss_pkg::LENGTH_BITS-1:0]    length_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lzss_pkg::BYTE_BITS-1:0]      out_byte,
    output logic                                last_of_run
);

    // Commands from the controller, status back from the datapath.
    lzss_pkg::dp_cmd_t  cmd;
    lzss_pkg::dp_stat_t stat;

    // The controller owns token acceptance and the byte issue sequence.
    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the token, the window and the output register.
    lzss_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .is_literal     (is_literal),
        .literal_byte   (literal_byte),
        .match_position (match_position),
        .length_code    (length_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run)
    );

endmodule

### tb/lzss_token_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// LZSS token decompressor checker
// Watches the token and byte channels of the decompressor, keeps its own
// copy of the history window and compares every delivered byte, in order,
// with the byte that the accepted tokens call for.
// ============================================================================
module lzss_token_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               is_literal,
    input  logic [lzss_pkg::BYTE_BITS-1:0]     literal_byte,
    input  logic [lzss_pkg::POSITION_BITS-1:0] match_position,
    input  logic [lzss_pkg::LENGTH_BITS-1:0]   length_code,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [lzss_pkg::BYTE_BITS-1:0]     out_byte,
    input  logic                               last_of_run,
    output int                                 mismatches,
    output int                                 pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [lzss_pkg::BYTE_BITS-1:0] data;
        logic                           last;
    } out_beat_t;

    logic [lzss_pkg::BYTE_BITS-1:0]     window [lzss_pkg::WIN_DEPTH];
    logic [lzss_pkg::POSITION_BITS-1:0] wr_ptr;
    out_beat_t                          expected_beats [$];
    int                                 error_count = 0;

    // Same state as after reset: all zeros, next write goes to entry 1.
    task automatic clear_window();
        for (int i = 0; i < lzss_pkg::WIN_DEPTH; i++)
        begin
            window[i] = '0;
        end
        wr_ptr = lzss_pkg::POSITION_BITS'(1);
    endtask

    task automatic emit_byte(input logic [lzss_pkg::BYTE_BITS-1:0] data, input logic last);
        out_beat_t beat;
        beat.data = data;
        beat.last = last;
        expected_beats.push_back(beat);
        window[wr_ptr] = data;
        wr_ptr = wr_ptr + 1'b1;
    endtask

    // A copy walks byte by byte, so an overlapping source sees its own output.
    task automatic expand_token();
        int unsigned                        run_len;
        logic [lzss_pkg::POSITION_BITS-1:0] src;
        if (is_literal)
        begin
            emit_byte(literal_byte, 1'b1);
        end
        else if (match_position == '0)
        begin
            clear_window();
        end
        else
        begin
            run_len = int'(length_code) + lzss_pkg::MIN_MATCH_OFFSET + 1;
            src     = match_position;
            for (int unsigned i = 0; i < run_len; i++)
            begin
                emit_byte(window[src], i == run_len - 1);
                src = src + 1'b1;
            end
        end
    endtask

    task automatic check_beat();
        out_beat_t want;
        if (expected_beats.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("%0t ns: byte %02h (last %0b) delivered with none outstanding",
                         $realtime, out_byte, last_of_run);
            end
        end
        else
        begin
            want = expected_beats.pop_front();
            if (out_byte !== want.data || last_of_run !== want.last)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("%0t ns: expected %02h (last %0b), got %02h (last %0b)",
                             $realtime, want.data, want.last, out_byte, last_of_run);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            expected_beats.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_beat();
            end
            if (in_valid && !in_stall)
            begin
                expand_token();
            end
        end
        mismatches <= error_count;
        pending    <= expected_beats.size();
    end

endmodule

### tb/tb_lzss_token_decompressor.sv
`timescale 1ns / 1ps
// ============================================================================
// LZSS token decompressor testbench
// Feeds directed and random token streams into the decompressor with random
// gaps on the token side and random stalls on the byte side, and leaves all
// checking of the delivered bytes to the checker that sits beside the block.
// ============================================================================
module tb_lzss_token_decompressor;

    typedef logic [lzss_pkg::BYTE_BITS-1:0]     byte_t;
    typedef logic [lzss_pkg::POSITION_BITS-1:0] pos_t;
    typedef logic [lzss_pkg::LENGTH_BITS-1:0]   len_t;

    // Random tokens after the twenty directed ones.
    localparam int RANDOM_ITEMS = 200;
    // Random tokens with short streams before the long stream starts.
    localparam int MIXED_ITEMS  = 30;
    // The byte side stops taking bytes for a long stretch once this many
    // tokens have gone in, so that the block backs up into its token input.
    localparam int HOLD_AT_ITEM = 45;
    localparam int HOLD_CYCLES  = 400;
    // Cycles allowed after the last expected byte for stray output.
    localparam int DRAIN_CYCLES = 24;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  is_literal;
    byte_t literal_byte;
    pos_t  match_position;
    len_t  length_code;
    logic  out_valid;
    logic  out_stall;
    byte_t out_byte;
    logic  last_of_run;

    int mismatches;
    int pending;

    // Token-side bookkeeping. The write pointer is tracked here only to aim
    // match sources near recent history; the checker does the prediction.
    int   sent_items;
    logic send_burst;
    pos_t next_write;

    lzss_token_decompressor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .is_literal     (is_literal),
        .literal_byte   (literal_byte),
        .match_position (match_position),
        .length_code    (length_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run)
    );

    lzss_token_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .is_literal     (is_literal),
        .literal_byte   (literal_byte),
        .match_position (match_position),
        .length_code    (length_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // 4 ns clock period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic byte_t rand_byte();
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic pos_t rand_pos();
        return pos_t'($urandom_range(0, lzss_pkg::WIN_DEPTH - 1));
    endfunction

    function automatic len_t rand_len();
        return len_t'($urandom_range(0, (1 << lzss_pkg::LENGTH_BITS) - 1));
    endfunction

    // Copy source for a random match. Short distances make the copy overlap
    // its own output (a distance of one repeats the last byte), medium ones
    // hit recent history, and the rest land anywhere in the window, written
    // or not. Position zero would end the stream, so it is moved off.
    function automatic pos_t pick_source();
        pos_t pos;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            pos = next_write - pos_t'($urandom_range(1, 4));
        end
        else if (sel < 55)
        begin
            pos = next_write - pos_t'($urandom_range(1, 64));
        end
        else
        begin
            pos = pos_t'($urandom_range(1, lzss_pkg::WIN_DEPTH - 1));
        end
        if (pos == '0)
        begin
            pos = pos_t'(1);
        end
        return pos;
    endfunction

    // Offers one token and returns at the edge where it is taken. Before the
    // token, the sender may idle for a random gap; while idle, the payload
    // carries noise that the block has to ignore. The valid line is driven
    // once per time step, so back-to-back tokens keep it high throughout.
    task automatic send_token(input logic  lit,
                              input byte_t data,
                              input pos_t  pos,
                              input len_t  len);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 29) == 0)
        begin
            send_burst = !send_burst;
        end
        if (gap > 0)
        begin
            in_valid       <= 1'b0;
            is_literal     <= 1'($urandom_range(0, 1));
            literal_byte   <= rand_byte();
            match_position <= rand_pos();
            length_code    <= rand_len();
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        is_literal     <= lit;
        literal_byte   <= data;
        match_position <= pos;
        length_code    <= len;
        do @(posedge clk); while (in_stall);
        sent_items++;

        if (lit)
        begin
            next_write = next_write + 1'b1;
        end
        else if (pos == '0)
        begin
            next_write = pos_t'(1);
        end
        else
        begin
            next_write = next_write + pos_t'(len) + pos_t'(lzss_pkg::MIN_MATCH_OFFSET + 1);
        end
    endtask

    // Literal and end tokens carry random values in the fields they ignore.
    task automatic send_literal(input byte_t data);
        send_token(1'b1, data, rand_pos(), rand_len());
    endtask

    task automatic send_match(input pos_t pos, input len_t len);
        send_token(1'b0, rand_byte(), pos, len);
    endtask

    task automatic send_end();
        send_token(1'b0, rand_byte(), '0, rand_len());
    endtask

    // Token side: reset, directed tokens, random streams, then the verdict.
    initial
    begin : token_source
        int   n;
        int   sel;
        logic long_stream;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        is_literal     = 1'b0;
        literal_byte   = '0;
        match_position = '0;
        length_code    = '0;
        sent_items     = 0;
        send_burst     = 1'b0;
        next_write     = pos_t'(1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Literals with extreme bytes, one of them with a zero
        // position, which must not be taken for an end token.
        send_token(1'b1, 8'h00, '0, '0);
        send_token(1'b1, 8'hFF, {lzss_pkg::POSITION_BITS{1'b1}},
                   {lzss_pkg::LENGTH_BITS{1'b1}});
        send_literal(8'hA5);
        send_literal(8'h5A);
        // Shortest match, then a longest match whose source overlaps the
        // bytes it writes, then a run from a distance of one.
        send_match(pos_t'(1), len_t'(0));
        send_match(pos_t'(4), len_t'(15));
        send_match(pos_t'(23), len_t'(3));
        // Source that wraps from the top of the window to the bottom.
        send_match(pos_t'(lzss_pkg::WIN_DEPTH - 1), len_t'(15));
        // Source in entries never written since reset.
        send_match(pos_t'(lzss_pkg::WIN_DEPTH / 2), len_t'(7));
        // End of stream, then a match starting right at the reset write
        // pointer, so every byte read is one just cleared or just written.
        send_end();
        send_match(pos_t'(1), len_t'(15));
        send_literal(8'h3C);
        send_match(pos_t'(18), len_t'(0));
        // Two end tokens back to back.
        send_end();
        send_end();
        send_literal(8'h81);
        // Alternating bit patterns in position and length.
        send_match(12'hAAA, 4'hA);
        send_match(12'h555, 4'h5);
        send_literal(8'h7E);
        send_match(pos_t'(2), len_t'(15));

        // Random part. Short mixed streams first, then one long stream of
        // mostly longest matches that runs to the end of the test.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            long_stream = (n >= MIXED_ITEMS);
            sel = $urandom_range(0, 99);
            if (long_stream)
            begin
                if (sel < 10)
                begin
                    send_literal(rand_byte());
                end
                else if ($urandom_range(0, 99) < 85)
                begin
                    send_match(pick_source(), {lzss_pkg::LENGTH_BITS{1'b1}});
                end
                else
                begin
                    send_match(pick_source(), rand_len());
                end
            end
            else
            begin
                if (sel < 10)
                begin
                    send_end();
                end
                else if (sel < 45)
                begin
                    send_literal(rand_byte());
                end
                else
                begin
                    send_match(pick_source(), rand_len());
                end
            end
            n++;
        end
        in_valid <= 1'b0;

        // Wait for every expected byte, then a drain period in which a stray
        // byte would still be caught.
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Byte side: before each byte it stalls for a random number of cycles,
    // with bursts of no stalling now and then. Once, it stalls for a long
    // stretch while tokens keep coming, which fills the block up.
    initial
    begin : byte_sink
        int   stall_len;
        logic recv_burst;
        logic hold_done;

        out_stall  = 1'b0;
        recv_burst = 1'b0;
        hold_done  = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!hold_done && sent_items >= HOLD_AT_ITEM)
            begin
                stall_len = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
            begin
                stall_len = recv_burst ? 0 : $urandom_range(0, 9);
            end
            if ($urandom_range(0, 29) == 0)
            begin
                recv_burst = !recv_burst;
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
